[rtl/ffha_pkg.sv]
// Shared types and constants of the first-fit heap allocator.
// Used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ffha_pkg;

  // Fixed sizes of the block layout, in bytes.
  localparam logic [31:0] HDR_BYTES   = 32'd32;
  localparam logic [31:0] MIN_PAYLOAD = 32'd32;
  localparam logic [31:0] FOOT_BYTES  = 32'd4;
  localparam logic [31:0] SPLIT_MIN   = 32'd64;
  localparam logic [31:0] MIN_HEAP    = 32'd80;
  localparam logic [31:0] RESET_HEAP  = 32'd1048576;

  // Configuration register indexes.
  localparam int          CFG_INDEX_W    = 1;
  localparam logic [0:0]  REG_HEAP_BASE  = 1'b0;
  localparam logic [0:0]  REG_HEAP_BYTES = 1'b1;

  // Operation codes.
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_OOM     = 3'd1;
  localparam logic [2:0] ST_ZERO    = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_DOUBLE  = 3'd4;

  // Datapath command codes.
  typedef logic [4:0] cmd_code_t;
  localparam cmd_code_t CMD_NOP         = 5'd0;
  localparam cmd_code_t CMD_INIT        = 5'd1;
  localparam cmd_code_t CMD_START       = 5'd2;
  localparam cmd_code_t CMD_SET_ST      = 5'd3;
  localparam cmd_code_t CMD_RD_J        = 5'd4;
  localparam cmd_code_t CMD_NEXT        = 5'd5;
  localparam cmd_code_t CMD_TAKE        = 5'd6;
  localparam cmd_code_t CMD_SHUP_INIT   = 5'd7;
  localparam cmd_code_t CMD_RD_JM1      = 5'd8;
  localparam cmd_code_t CMD_WR_J_BACK   = 5'd9;
  localparam cmd_code_t CMD_ALLOC_SPLIT = 5'd10;
  localparam cmd_code_t CMD_ALLOC_WHOLE = 5'd11;
  localparam cmd_code_t CMD_ALLOC_FIN   = 5'd12;
  localparam cmd_code_t CMD_FREE_MARK   = 5'd13;
  localparam cmd_code_t CMD_RD_I1       = 5'd14;
  localparam cmd_code_t CMD_MERGE_R     = 5'd15;
  localparam cmd_code_t CMD_WR_I        = 5'd16;
  localparam cmd_code_t CMD_DROP_I1     = 5'd17;
  localparam cmd_code_t CMD_DROP_I      = 5'd18;
  localparam cmd_code_t CMD_RD_J1       = 5'd19;
  localparam cmd_code_t CMD_WR_J_FWD    = 5'd20;
  localparam cmd_code_t CMD_DEC_COUNT   = 5'd21;
  localparam cmd_code_t CMD_RD_IM1      = 5'd22;
  localparam cmd_code_t CMD_MERGE_L     = 5'd23;

  // One entry of the block table.
  typedef struct packed {
    logic [31:0] off;
    logic [31:0] pay;
    logic        free;
  } entry_t;

  // Command from controller to datapath.
  typedef struct packed {
    cmd_code_t  code;
    logic [2:0] st;
  } dp_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic init_pend;
    logic op_free;
    logic zero;
    logic bad_range;
    logic j_end;
    logic hit_alloc;
    logic hit_free;
    logic split_ok;
    logic shup_done;
    logic cur_free;
    logic has_right;
    logic rd_free;
    logic merged_r;
    logic drop_done;
    logic i_nonzero;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/ffha_if.sv]
// Request and response channel interfaces of the heap allocator.
// Depend on nothing beyond the language.
`timescale 1ns / 1ps
`default_nettype none

// Request channel: one word per allocate or free.
interface ffha_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [31:0] request_size;
  logic [47:0] release_address;

  modport source (output valid, output operation, output request_size,
                  output release_address, input ready);
  modport sink (input valid, input operation, input request_size,
                input release_address, output ready);
endinterface

// Response channel: one word per request.
interface ffha_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [47:0] payload_address;
  logic [31:0] usable_bytes;
  logic [31:0] bytes_in_use;
  logic [31:0] bytes_free;
  logic [31:0] peak_in_use;

  modport source (output valid, output status, output payload_address,
                  output usable_bytes, output bytes_in_use, output bytes_free,
                  output peak_in_use, input ready);
  modport sink (input valid, input status, input payload_address,
                input usable_bytes, input bytes_in_use, input bytes_free,
                input peak_in_use, output ready);
endinterface

`default_nettype wire

[rtl/ffha_ctrl.sv]
// Controller state machine of the heap allocator.
// Depends on ffha_pkg; drives the datapath by command words.
`timescale 1ns / 1ps
`default_nettype none

module ffha_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     req_valid,
  output logic                    req_ready,
  output logic                    rsp_valid,
  input  wire                     rsp_ready,
  input  wire ffha_pkg::dp_stat_t stat,
  output ffha_pkg::dp_cmd_t       cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_PREP    = 5'd1;
  localparam logic [4:0] S_A_RD    = 5'd2;
  localparam logic [4:0] S_A_CHK   = 5'd3;
  localparam logic [4:0] S_A_DEC   = 5'd4;
  localparam logic [4:0] S_A_SH_RD = 5'd5;
  localparam logic [4:0] S_A_SH_WR = 5'd6;
  localparam logic [4:0] S_A_FIN   = 5'd7;
  localparam logic [4:0] S_F_RD    = 5'd8;
  localparam logic [4:0] S_F_CHK   = 5'd9;
  localparam logic [4:0] S_F_DEC   = 5'd10;
  localparam logic [4:0] S_F_R_RD  = 5'd11;
  localparam logic [4:0] S_F_R_CHK = 5'd12;
  localparam logic [4:0] S_F_WR    = 5'd13;
  localparam logic [4:0] S_F_D1    = 5'd14;
  localparam logic [4:0] S_D_RD    = 5'd15;
  localparam logic [4:0] S_D_WR    = 5'd16;
  localparam logic [4:0] S_F_L_RD  = 5'd17;
  localparam logic [4:0] S_F_L_CHK = 5'd18;
  localparam logic [4:0] S_F_D0    = 5'd19;
  localparam logic [4:0] S_OUT     = 5'd20;

  logic [4:0] state;
  logic [4:0] state_next;
  // Set when a drop pass returns to the left-neighbor check.
  logic       ret_left;
  logic       ret_left_next;

  assign req_ready = (state == S_IDLE) && !stat.init_pend;
  assign rsp_valid = (state == S_OUT);

  // Next state and command.
  always_comb begin
    state_next    = state;
    ret_left_next = ret_left;
    cmd.code      = ffha_pkg::CMD_NOP;
    cmd.st        = ffha_pkg::ST_OK;
    case (state)
      S_IDLE: begin
        if (stat.init_pend) begin
          cmd.code = ffha_pkg::CMD_INIT;
        end else if (req_valid) begin
          cmd.code   = ffha_pkg::CMD_START;
          state_next = S_PREP;
        end
      end
      S_PREP: begin
        if (!stat.op_free) begin
          if (stat.zero) begin
            cmd.code   = ffha_pkg::CMD_SET_ST;
            cmd.st     = ffha_pkg::ST_ZERO;
            state_next = S_OUT;
          end else begin
            state_next = S_A_RD;
          end
        end else if (stat.bad_range) begin
          cmd.code   = ffha_pkg::CMD_SET_ST;
          cmd.st     = ffha_pkg::ST_INVALID;
          state_next = S_OUT;
        end else begin
          state_next = S_F_RD;
        end
      end
      // First-fit search.
      S_A_RD: begin
        if (stat.j_end) begin
          cmd.code   = ffha_pkg::CMD_SET_ST;
          cmd.st     = ffha_pkg::ST_OOM;
          state_next = S_OUT;
        end else begin
          cmd.code   = ffha_pkg::CMD_RD_J;
          state_next = S_A_CHK;
        end
      end
      S_A_CHK: begin
        if (stat.hit_alloc) begin
          cmd.code   = ffha_pkg::CMD_TAKE;
          state_next = S_A_DEC;
        end else begin
          cmd.code   = ffha_pkg::CMD_NEXT;
          state_next = S_A_RD;
        end
      end
      S_A_DEC: begin
        if (stat.split_ok) begin
          cmd.code   = ffha_pkg::CMD_SHUP_INIT;
          state_next = S_A_SH_RD;
        end else begin
          cmd.code   = ffha_pkg::CMD_ALLOC_WHOLE;
          state_next = S_A_FIN;
        end
      end
      // Open a slot after the granted block.
      S_A_SH_RD: begin
        if (stat.shup_done) begin
          cmd.code   = ffha_pkg::CMD_ALLOC_SPLIT;
          state_next = S_A_FIN;
        end else begin
          cmd.code   = ffha_pkg::CMD_RD_JM1;
          state_next = S_A_SH_WR;
        end
      end
      S_A_SH_WR: begin
        cmd.code   = ffha_pkg::CMD_WR_J_BACK;
        state_next = S_A_SH_RD;
      end
      S_A_FIN: begin
        cmd.code   = ffha_pkg::CMD_ALLOC_FIN;
        state_next = S_OUT;
      end
      // Search for the named block.
      S_F_RD: begin
        if (stat.j_end) begin
          cmd.code   = ffha_pkg::CMD_SET_ST;
          cmd.st     = ffha_pkg::ST_INVALID;
          state_next = S_OUT;
        end else begin
          cmd.code   = ffha_pkg::CMD_RD_J;
          state_next = S_F_CHK;
        end
      end
      S_F_CHK: begin
        if (stat.hit_free) begin
          cmd.code   = ffha_pkg::CMD_TAKE;
          state_next = S_F_DEC;
        end else begin
          cmd.code   = ffha_pkg::CMD_NEXT;
          state_next = S_F_RD;
        end
      end
      S_F_DEC: begin
        if (stat.cur_free) begin
          cmd.code   = ffha_pkg::CMD_SET_ST;
          cmd.st     = ffha_pkg::ST_DOUBLE;
          state_next = S_OUT;
        end else begin
          cmd.code   = ffha_pkg::CMD_FREE_MARK;
          state_next = S_F_R_RD;
        end
      end
      // Merge with the right neighbor.
      S_F_R_RD: begin
        if (stat.has_right) begin
          cmd.code   = ffha_pkg::CMD_RD_I1;
          state_next = S_F_R_CHK;
        end else begin
          state_next = S_F_WR;
        end
      end
      S_F_R_CHK: begin
        if (stat.rd_free) begin
          cmd.code = ffha_pkg::CMD_MERGE_R;
        end
        state_next = S_F_WR;
      end
      S_F_WR: begin
        cmd.code   = ffha_pkg::CMD_WR_I;
        state_next = stat.merged_r ? S_F_D1 : S_F_L_RD;
      end
      S_F_D1: begin
        cmd.code      = ffha_pkg::CMD_DROP_I1;
        ret_left_next = 1'b1;
        state_next    = S_D_RD;
      end
      // Drop one entry by moving the tail down.
      S_D_RD: begin
        if (stat.drop_done) begin
          cmd.code   = ffha_pkg::CMD_DEC_COUNT;
          state_next = ret_left ? S_F_L_RD : S_OUT;
        end else begin
          cmd.code   = ffha_pkg::CMD_RD_J1;
          state_next = S_D_WR;
        end
      end
      S_D_WR: begin
        cmd.code   = ffha_pkg::CMD_WR_J_FWD;
        state_next = S_D_RD;
      end
      // Merge into the left neighbor.
      S_F_L_RD: begin
        if (stat.i_nonzero) begin
          cmd.code   = ffha_pkg::CMD_RD_IM1;
          state_next = S_F_L_CHK;
        end else begin
          state_next = S_OUT;
        end
      end
      S_F_L_CHK: begin
        if (stat.rd_free) begin
          cmd.code   = ffha_pkg::CMD_MERGE_L;
          state_next = S_F_D0;
        end else begin
          state_next = S_OUT;
        end
      end
      S_F_D0: begin
        cmd.code      = ffha_pkg::CMD_DROP_I;
        ret_left_next = 1'b0;
        state_next    = S_D_RD;
      end
      S_OUT: begin
        if (rsp_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      ret_left <= 1'b0;
    end else begin
      state    <= state_next;
      ret_left <= ret_left_next;
    end
  end

endmodule

`default_nettype wire

[rtl/ffha_dp.sv]
// Datapath of the heap allocator: block table memory, totals and result word.
// Depends on ffha_pkg; executes one command word of ffha_ctrl per cycle.
`timescale 1ns / 1ps
`default_nettype none

module ffha_dp #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_write,
  input  wire  [ffha_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [47:0]                         cfg_data,
  input  wire                                 in_operation,
  input  wire  [31:0]                         in_request_size,
  input  wire  [47:0]                         in_release_address,
  input  wire  ffha_pkg::dp_cmd_t             cmd,
  output ffha_pkg::dp_stat_t                  stat,
  output logic [2:0]                          out_status,
  output logic [47:0]                         out_payload_address,
  output logic [31:0]                         out_usable_bytes,
  output logic [31:0]                         out_bytes_in_use,
  output logic [31:0]                         out_bytes_free,
  output logic [31:0]                         out_peak_in_use
);

  localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);

  // Block table.
  ffha_pkg::entry_t mem [MAX_BLOCKS];
  ffha_pkg::entry_t rdata;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  ffha_pkg::entry_t wr_data;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;

  // Configuration and totals.
  logic [47:0] heap_base;
  logic [31:0] heap_bytes;
  logic        init_pend;
  logic [CW-1:0] count,  count_next;
  logic [31:0] used,   used_next;
  logic [31:0] free_b, free_next;
  logic [31:0] peak,   peak_next;

  // Per-request working registers.
  logic              op,       op_next;
  logic              zero,     zero_next;
  logic [32:0]       need,     need_next;
  logic [47:0]       rel,      rel_next;
  logic              addr_lt,  addr_lt_next;
  logic [CW-1:0]     j,        j_next;
  logic [IW-1:0]     i,        i_next;
  ffha_pkg::entry_t  cur,      cur_next;
  logic              merged_r, merged_r_next;
  logic [2:0]        st,       st_next;
  logic [47:0]       pa,       pa_next;
  logic [31:0]       ub,       ub_next;

  logic [31:0] size_clamp;
  logic [CW-1:0] i_ext;
  logic [CW-1:0] i_plus1;
  logic [CW-1:0] j_minus1;
  logic [CW-1:0] j_plus1;
  logic [31:0] used_sum;
  logic [31:0] hb_raw;

  assign i_ext    = CW'(i);
  assign i_plus1  = i_ext + 1'b1;
  assign j_minus1 = j - 1'b1;
  assign j_plus1  = j + 1'b1;
  assign used_sum = used + cur.pay;
  assign size_clamp = (in_request_size < ffha_pkg::MIN_PAYLOAD) ?
                      ffha_pkg::MIN_PAYLOAD : in_request_size;
  assign hb_raw = {cfg_data[31:4], 4'b0000};

  // Status toward the controller.
  always_comb begin
    stat.init_pend = init_pend;
    stat.op_free   = (op == ffha_pkg::OP_FREE);
    stat.zero      = zero;
    stat.bad_range = addr_lt || (rel >= {16'd0, heap_bytes});
    stat.j_end     = (j >= count);
    stat.hit_alloc = rdata.free && ({1'b0, rdata.pay} >= need);
    stat.hit_free  = ({15'd0, {1'b0, rdata.off} + 33'd32} == rel);
    stat.split_ok  = ((cur.pay - need[31:0]) >= ffha_pkg::SPLIT_MIN) &&
                     (count < CW'(MAX_BLOCKS));
    stat.shup_done = (j <= i_plus1);
    stat.cur_free  = cur.free;
    stat.has_right = (i_plus1 < count);
    stat.rd_free   = rdata.free;
    stat.merged_r  = merged_r;
    stat.drop_done = ({1'b0, j_plus1} >= {1'b0, count});
    stat.i_nonzero = (i != '0);
  end

  // Command decode.
  always_comb begin
    wr_en         = 1'b0;
    wr_addr       = i;
    wr_data       = cur;
    rd_en         = 1'b0;
    rd_addr       = j[IW-1:0];
    count_next    = count;
    used_next     = used;
    free_next     = free_b;
    peak_next     = peak;
    op_next       = op;
    zero_next     = zero;
    need_next     = need;
    rel_next      = rel;
    addr_lt_next  = addr_lt;
    j_next        = j;
    i_next        = i;
    cur_next      = cur;
    merged_r_next = merged_r;
    st_next       = st;
    pa_next       = pa;
    ub_next       = ub;
    case (cmd.code)
      ffha_pkg::CMD_INIT: begin
        wr_en      = 1'b1;
        wr_addr    = '0;
        wr_data    = '{off: 32'd0, pay: heap_bytes - ffha_pkg::HDR_BYTES, free: 1'b1};
        count_next = CW'(1);
        used_next  = '0;
        free_next  = heap_bytes - ffha_pkg::HDR_BYTES;
        peak_next  = '0;
      end
      ffha_pkg::CMD_START: begin
        op_next       = in_operation;
        zero_next     = (in_request_size == 32'd0);
        need_next     = ({1'b0, size_clamp} + 33'd19) & ~33'd15;
        rel_next      = in_release_address - heap_base;
        addr_lt_next  = (in_release_address < heap_base);
        j_next        = '0;
        merged_r_next = 1'b0;
        st_next       = ffha_pkg::ST_OK;
        pa_next       = '0;
        ub_next       = '0;
      end
      ffha_pkg::CMD_SET_ST: begin
        st_next = cmd.st;
      end
      ffha_pkg::CMD_RD_J: begin
        rd_en   = 1'b1;
        rd_addr = j[IW-1:0];
      end
      ffha_pkg::CMD_NEXT: begin
        j_next = j_plus1;
      end
      ffha_pkg::CMD_TAKE: begin
        cur_next = rdata;
        i_next   = j[IW-1:0];
      end
      ffha_pkg::CMD_SHUP_INIT: begin
        j_next = count;
      end
      ffha_pkg::CMD_RD_JM1: begin
        rd_en   = 1'b1;
        rd_addr = j_minus1[IW-1:0];
      end
      ffha_pkg::CMD_WR_J_BACK: begin
        wr_en   = 1'b1;
        wr_addr = j[IW-1:0];
        wr_data = rdata;
        j_next  = j_minus1;
      end
      ffha_pkg::CMD_ALLOC_SPLIT: begin
        wr_en        = 1'b1;
        wr_addr      = i_plus1[IW-1:0];
        wr_data.off  = cur.off + ffha_pkg::HDR_BYTES + need[31:0];
        wr_data.pay  = cur.pay - need[31:0] - ffha_pkg::HDR_BYTES;
        wr_data.free = 1'b1;
        count_next   = count + 1'b1;
        cur_next.pay = need[31:0];
        free_next    = free_b - (need[31:0] + ffha_pkg::HDR_BYTES);
      end
      ffha_pkg::CMD_ALLOC_WHOLE: begin
        free_next = free_b - cur.pay;
      end
      ffha_pkg::CMD_ALLOC_FIN: begin
        wr_en        = 1'b1;
        wr_addr      = i;
        wr_data      = cur;
        wr_data.free = 1'b0;
        used_next    = used_sum;
        peak_next    = (used_sum > peak) ? used_sum : peak;
        pa_next      = heap_base + {16'd0, cur.off} + 48'd32;
        ub_next      = cur.pay - ffha_pkg::FOOT_BYTES;
        st_next      = ffha_pkg::ST_OK;
      end
      ffha_pkg::CMD_FREE_MARK: begin
        used_next     = used - cur.pay;
        free_next     = free_b + cur.pay;
        cur_next.free = 1'b1;
      end
      ffha_pkg::CMD_RD_I1: begin
        rd_en   = 1'b1;
        rd_addr = i_plus1[IW-1:0];
      end
      ffha_pkg::CMD_MERGE_R: begin
        cur_next.pay  = cur.pay + ffha_pkg::HDR_BYTES + rdata.pay;
        free_next     = free_b + ffha_pkg::HDR_BYTES;
        merged_r_next = 1'b1;
      end
      ffha_pkg::CMD_WR_I: begin
        wr_en   = 1'b1;
        wr_addr = i;
        wr_data = cur;
      end
      ffha_pkg::CMD_DROP_I1: begin
        j_next = i_plus1;
      end
      ffha_pkg::CMD_DROP_I: begin
        j_next = i_ext;
      end
      ffha_pkg::CMD_RD_J1: begin
        rd_en   = 1'b1;
        rd_addr = j_plus1[IW-1:0];
      end
      ffha_pkg::CMD_WR_J_FWD: begin
        wr_en   = 1'b1;
        wr_addr = j[IW-1:0];
        wr_data = rdata;
        j_next  = j_plus1;
      end
      ffha_pkg::CMD_DEC_COUNT: begin
        count_next = count - 1'b1;
      end
      ffha_pkg::CMD_RD_IM1: begin
        rd_en   = 1'b1;
        rd_addr = i - 1'b1;
      end
      ffha_pkg::CMD_MERGE_L: begin
        wr_en        = 1'b1;
        wr_addr      = i - 1'b1;
        wr_data.off  = rdata.off;
        wr_data.pay  = rdata.pay + ffha_pkg::HDR_BYTES + cur.pay;
        wr_data.free = 1'b1;
        free_next    = free_b + ffha_pkg::HDR_BYTES;
      end
      default: begin
      end
    endcase
  end

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // Configuration and totals.
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base  <= '0;
      heap_bytes <= ffha_pkg::RESET_HEAP;
      init_pend  <= 1'b1;
      count      <= CW'(1);
      used       <= '0;
      free_b     <= ffha_pkg::RESET_HEAP - ffha_pkg::HDR_BYTES;
      peak       <= '0;
    end else begin
      count  <= count_next;
      used   <= used_next;
      free_b <= free_next;
      peak   <= peak_next;
      if (cmd.code == ffha_pkg::CMD_INIT) begin
        init_pend <= 1'b0;
      end
      if (cfg_write) begin
        if (cfg_index == ffha_pkg::REG_HEAP_BASE) begin
          heap_base <= {cfg_data[47:4], 4'b0000};
        end else begin
          heap_bytes <= (hb_raw < ffha_pkg::MIN_HEAP) ? ffha_pkg::MIN_HEAP : hb_raw;
          init_pend  <= 1'b1;
        end
      end
    end
  end

  // Per-request working registers.
  always_ff @(posedge clk) begin
    op       <= op_next;
    zero     <= zero_next;
    need     <= need_next;
    rel      <= rel_next;
    addr_lt  <= addr_lt_next;
    j        <= j_next;
    i        <= i_next;
    cur      <= cur_next;
    merged_r <= merged_r_next;
    st       <= st_next;
    pa       <= pa_next;
    ub       <= ub_next;
  end

  assign out_status          = st;
  assign out_payload_address = pa;
  assign out_usable_bytes    = ub;
  assign out_bytes_in_use    = used;
  assign out_bytes_free      = free_b;
  assign out_peak_in_use     = peak;

endmodule

`default_nettype wire

[rtl/first_fit_heap_allocator.sv]
// Top level of the first-fit heap allocator with coalescing.
// Depends on ffha_pkg, ffha_if, ffha_ctrl and ffha_dp.
//
//   channel  | direction | handshake    | word
//   req      | in        | valid/ready  | operation, request_size, release_address
//   rsp      | out       | valid/ready  | status, addresses, byte totals
//   cfg      | in        | cfg_write    | cfg_index, cfg_data
//
// One request is handled at a time. An allocate searches the table entry by
// entry and moves the entries after the granted block when it is split; a free
// searches for the named block and moves the tail entries down for each merge.
// The table memory has a registered read. After reset and after each
// heap_bytes write the table is rebuilt before req is ready. The response
// word is held until rsp.ready.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_heap_allocator #(
  parameter int MAX_BLOCKS = 256
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_write,
  input  wire [ffha_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire [47:0]                       cfg_data,
  ffha_req_if.sink                         req,
  ffha_rsp_if.source                       rsp
);

  ffha_pkg::dp_cmd_t  cmd;
  ffha_pkg::dp_stat_t stat;

  // Sequencer.
  ffha_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Table, totals and result word.
  ffha_dp #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cfg_write           (cfg_write),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_operation        (req.operation),
    .in_request_size     (req.request_size),
    .in_release_address  (req.release_address),
    .cmd                 (cmd),
    .stat                (stat),
    .out_status          (rsp.status),
    .out_payload_address (rsp.payload_address),
    .out_usable_bytes    (rsp.usable_bytes),
    .out_bytes_in_use    (rsp.bytes_in_use),
    .out_bytes_free      (rsp.bytes_free),
    .out_peak_in_use     (rsp.peak_in_use)
  );

endmodule

`default_nettype wire
